// ===== sv/ktaq_pkg.sv =====
// Shared types and constants for the keypad/touch autorepeat qualifier.
// No dependencies; used by the channel interfaces and all modules.
`default_nettype none

package ktaq_pkg;

  localparam int KEY_BITS = 12;

  // key bit positions
  localparam int KEY_A     = 0;
  localparam int KEY_START = 3;
  localparam int KEY_R     = 8;
  localparam int KEY_L     = 9;
  localparam int KEY_X     = 10;
  localparam int KEY_Y     = 11;

  typedef logic [KEY_BITS-1:0] keys_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_START_X = 2'd1,
    MODE_SWAP_XY = 2'd2,
    MODE_L_IS_A  = 2'd3
  } button_mode_t;

  typedef enum logic [1:0] {
    TOUCH_OK    = 2'd0,
    TOUCH_X_BAD = 2'd1,
    TOUCH_Y_BAD = 2'd2,
    TOUCH_BAD   = 2'd3
  } touch_validity_t;

  typedef enum logic [1:0] {
    REG_BUTTON_MODE  = 2'd0,
    REG_REPEAT_RATE  = 2'd1,
    REG_REPEAT_DELAY = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  localparam logic [7:0] RATE_RESET  = 8'd4;
  localparam logic [7:0] DELAY_RESET = 8'd8;

  typedef struct packed {
    logic       lid_closed;
    keys_t      pad_bits;
    logic       touch_down;
    logic [1:0] touch_validity;
    logic [7:0] sample_x;
    logic [7:0] sample_y;
  } in_word_t;

  typedef struct packed {
    keys_t      pressed_keys;
    keys_t      held_keys;
    keys_t      repeat_keys;
    logic       touch_pressed;
    logic       touch_held;
    logic [7:0] touch_x;
    logic [7:0] touch_y;
  } out_word_t;

  typedef struct packed {
    reg_index_t index;
    logic [7:0] data;
  } cfg_word_t;

endpackage

`default_nettype wire

// ===== sv/ktaq_if.sv =====
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on ktaq_pkg for the word types.
`default_nettype none

interface ktaq_in_if;
  logic                valid;
  logic                ready;
  ktaq_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ktaq_out_if;
  logic                valid;
  logic                ready;
  ktaq_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ktaq_cfg_if;
  logic                valid;
  logic                ready;
  ktaq_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ktaq_remap.sv =====
// Button remap by mode: START also X, X/Y swap, or L as A with L/R cleared.
// Depends on ktaq_pkg.
`default_nettype none

module ktaq_remap (
  input  wire ktaq_pkg::button_mode_t mode,
  input  wire ktaq_pkg::keys_t        keys,
  output ktaq_pkg::keys_t             mapped
);

  always_comb begin
    mapped = keys;
    case (mode)
      ktaq_pkg::MODE_START_X: begin
        if (keys[ktaq_pkg::KEY_START]) mapped[ktaq_pkg::KEY_X] = 1'b1;
      end
      ktaq_pkg::MODE_SWAP_XY: begin
        mapped[ktaq_pkg::KEY_X] = keys[ktaq_pkg::KEY_Y];
        mapped[ktaq_pkg::KEY_Y] = keys[ktaq_pkg::KEY_X];
      end
      ktaq_pkg::MODE_L_IS_A: begin
        if (keys[ktaq_pkg::KEY_L]) mapped[ktaq_pkg::KEY_A] = 1'b1;
        mapped[ktaq_pkg::KEY_L] = 1'b0;
        mapped[ktaq_pkg::KEY_R] = 1'b0;
      end
      default: begin
        mapped = keys;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/keypad_touch_autorepeat_qualifier.sv =====
// Keypad and touch qualifier with autorepeat, top level.
// Depends on ktaq_pkg, the channel interfaces in ktaq_if.sv and ktaq_remap.
//
// Usage:
//  - sample_in: one word per frame (lid, raw pad bits, touch sample + validity).
//  - result_out: one word per accepted sample (pressed, held, repeat keys after
//    remap, touch edge/hold, kept coordinates).
//  - cfg: register writes (index, data); always ready, one write per cycle.
//    Write only while no sample is in flight.
//  - Result: a sample's result word is registered and presented in the cycle
//    after the sample is accepted. Throughput: one word per cycle while result_out is not stalled.
//  - The per-sample logic (edge detect, 8-bit repeat timer, touch qualify)
//    sits between the state registers and the result register.
//  - Stall: sample_in.ready follows "result register empty or being taken",
//    so a new sample is taken in the same cycle the old result leaves.
//    While result_out is stalled, the result word holds.
//  - Reset (rst, synchronous): mode normal, rate 4, delay 8, key/timer/touch
//    state cleared, result register empty.
//  - Lid closed: result is all zero, touch hold clears, other state is kept.
`default_nettype none

module keypad_touch_autorepeat_qualifier (
  input  wire              clk,
  input  wire              rst,
  ktaq_in_if.sink          sample_in,
  ktaq_out_if.source       result_out,
  ktaq_cfg_if.sink         cfg
);

  // configuration
  ktaq_pkg::button_mode_t button_mode;
  logic [7:0]             repeat_rate;
  logic [7:0]             repeat_delay;

  // frame state
  ktaq_pkg::keys_t last_raw_keys;
  logic [7:0]      repeat_timer;
  logic            touch_hold_flag;
  logic [7:0]      kept_x;
  logic [7:0]      kept_y;

  // result register
  logic                out_valid;
  ktaq_pkg::out_word_t out_word;

  ktaq_pkg::in_word_t smp;
  logic               take;

  ktaq_pkg::keys_t pressed_raw;
  ktaq_pkg::keys_t repeat_raw;
  logic            same_hold;
  logic [7:0]      timer_dec;
  logic            timer_hit;
  logic [7:0]      repeat_timer_next;
  logic            tdown_q;
  logic            tpress;
  logic [7:0]      kept_x_next;
  logic [7:0]      kept_y_next;

  ktaq_pkg::keys_t pressed_map;
  ktaq_pkg::keys_t held_map;
  ktaq_pkg::keys_t repeat_map;

  assign smp  = sample_in.data;
  assign take = sample_in.valid && sample_in.ready;

  // result slot frees up in the cycle it is taken
  assign sample_in.ready = !out_valid || result_out.ready;
  assign cfg.ready       = 1'b1;

  // ---- key edge and autorepeat ----
  assign pressed_raw = smp.pad_bits & ~last_raw_keys;
  assign same_hold   = (smp.pad_bits != '0) && (smp.pad_bits == last_raw_keys);
  assign timer_dec   = repeat_timer - 8'd1;
  assign timer_hit   = same_hold && (timer_dec == 8'd0);

  always_comb begin
    if (!same_hold) begin
      repeat_timer_next = repeat_delay;
    end else if (timer_hit) begin
      repeat_timer_next = repeat_rate;
    end else begin
      repeat_timer_next = timer_dec;
    end
  end

  assign repeat_raw = timer_hit ? smp.pad_bits : pressed_raw;

  // ---- touch qualify ----
  // Full update on a valid sample; per-axis update only while held.
  // An invalid sample with no hold counts as touch up.
  always_comb begin
    kept_x_next = kept_x;
    kept_y_next = kept_y;
    tdown_q     = smp.touch_down;
    case (ktaq_pkg::touch_validity_t'(smp.touch_validity))
      ktaq_pkg::TOUCH_OK: begin
        kept_x_next = smp.sample_x;
        kept_y_next = smp.sample_y;
      end
      ktaq_pkg::TOUCH_X_BAD: begin
        if (touch_hold_flag) kept_y_next = smp.sample_y;
        else tdown_q = 1'b0;
      end
      ktaq_pkg::TOUCH_Y_BAD: begin
        if (touch_hold_flag) kept_x_next = smp.sample_x;
        else tdown_q = 1'b0;
      end
      default: begin
        if (!touch_hold_flag) tdown_q = 1'b0;
      end
    endcase
  end

  assign tpress = tdown_q && !touch_hold_flag;

  ktaq_remap u_remap_pressed (.mode(button_mode), .keys(pressed_raw),   .mapped(pressed_map));
  ktaq_remap u_remap_held    (.mode(button_mode), .keys(smp.pad_bits),  .mapped(held_map));
  ktaq_remap u_remap_repeat  (.mode(button_mode), .keys(repeat_raw),    .mapped(repeat_map));

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      button_mode  <= ktaq_pkg::MODE_NORMAL;
      repeat_rate  <= ktaq_pkg::RATE_RESET;
      repeat_delay <= ktaq_pkg::DELAY_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        ktaq_pkg::REG_BUTTON_MODE:  button_mode  <= ktaq_pkg::button_mode_t'(cfg.data.data[1:0]);
        ktaq_pkg::REG_REPEAT_RATE:  repeat_rate  <= cfg.data.data;
        ktaq_pkg::REG_REPEAT_DELAY: repeat_delay <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // ---- frame state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_keys   <= '0;
      repeat_timer    <= '0;
      touch_hold_flag <= 1'b0;
      kept_x          <= '0;
      kept_y          <= '0;
    end else if (take) begin
      if (smp.lid_closed) begin
        touch_hold_flag <= 1'b0;
      end else begin
        last_raw_keys   <= smp.pad_bits;
        repeat_timer    <= repeat_timer_next;
        touch_hold_flag <= tdown_q;
        kept_x          <= kept_x_next;
        kept_y          <= kept_y_next;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (smp.lid_closed) begin
        out_word <= '0;
      end else begin
        out_word.pressed_keys  <= pressed_map;
        out_word.held_keys     <= held_map;
        out_word.repeat_keys   <= repeat_map;
        out_word.touch_pressed <= tpress;
        out_word.touch_held    <= tdown_q;
        out_word.touch_x       <= kept_x_next;
        out_word.touch_y       <= kept_y_next;
      end
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.data  = out_word;

endmodule

`default_nettype wire
